// File: design/bekc_pkg.sv
// bekc_pkg: shared types, codes and constants for the end knot change block
// word layouts, controller command and status, register indexes
// no dependencies
`default_nettype none

package bekc_pkg;

  localparam int DEG_MAX    = 7;
  localparam int MAX_COORDS = 8;

  // input functions
  localparam logic [1:0] FUNC_OLD_KNOT = 2'd0;
  localparam logic [1:0] FUNC_NEW_KNOT = 2'd1;
  localparam logic [1:0] FUNC_CTRL     = 2'd2;
  localparam logic [1:0] FUNC_START    = 2'd3;

  // error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_ZERO  = 2'd1;
  localparam logic [1:0] ERR_SHORT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_DEGREE    = 2'd0;
  localparam logic [1:0] REG_SIDE      = 2'd1;
  localparam logic [1:0] REG_COORD_CNT = 2'd2;
  localparam logic [1:0] REG_LAST_KNOT = 2'd3;

  // quotient bits of the alpha divider
  localparam int QBITS = 19;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         slot;
    logic [2:0]         coord_sel;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [11:0]        point_index;
    logic [2:0]         coord_id;
    logic signed [31:0] coordinate;
    logic [1:0]         error;
    logic               last;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLRZ,
    OP_CRD,
    OP_WRW,
    OP_KRD1,
    OP_KRD2,
    OP_SETUP,
    OP_DIV,
    OP_ALPHA,
    OP_MUL,
    OP_BLEND,
    OP_RRD,
    OP_RWR,
    OP_ORD,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] c;
    logic [2:0] k;
    logic [2:0] x;
    logic [2:0] jj;
    logic [2:0] ii;
    logic       last;
    logic       short_err;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic [2:0]  deg;
    logic        side;
    logic [11:0] last_knot;
  } geom_t;

endpackage

`default_nettype wire

// File: design/bekc_ctrl.sv
// bekc_ctrl: sequencer for loads, the blending triangle and result delivery
// depends on bekc_pkg
`default_nettype none

module bekc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [1:0]     in_func,
  input  wire bekc_pkg::geom_t geom,
  input  wire logic [3:0]     nc,
  input  wire bekc_pkg::stat_t stat,
  output bekc_pkg::cmd_t      cmd
);
  import bekc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CRD, S_WRW, S_KRD1, S_KRD2, S_SETUP, S_DIV, S_ALPHA,
    S_MUL, S_BLEND, S_RRD, S_RWR, S_ORD, S_OUT, S_ERR
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] c_r, c_nxt, k_r, k_nxt, x_r, x_nxt, jj_r, jj_nxt, ii_r, ii_nxt;
  logic [4:0] bit_r, bit_nxt;
  logic [2:0] deg, nc_m1, j_first, j_final, i_first;
  logic       accept, short_kv, out_last;

  assign deg      = geom.deg;
  assign nc_m1    = 3'(nc - 4'd1);
  assign j_first  = geom.side ? 3'd0 : 3'd1;
  assign j_final  = geom.side ? 3'(deg - 3'd1) : deg;
  assign i_first  = geom.side ? 3'(deg - 3'd1) : deg;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign short_kv = geom.side && (geom.last_knot < 12'({deg, 1'b1}));
  assign out_last = (k_r == 3'(deg - 3'd1)) && (c_r == nc_m1);

  // command to the datapath
  always_comb begin
    cmd = '0;
    cmd.c    = c_r;
    cmd.k    = k_r;
    cmd.x    = x_r;
    cmd.jj   = jj_r;
    cmd.ii   = ii_r;
    cmd.last = out_last;
    cmd.op   = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (accept) cmd.op = (in_func == FUNC_START) ? OP_CLRZ : OP_LOAD;
      end
      S_CRD:   cmd.op = OP_CRD;
      S_WRW:   cmd.op = OP_WRW;
      S_KRD1:  cmd.op = OP_KRD1;
      S_KRD2:  cmd.op = OP_KRD2;
      S_SETUP: cmd.op = OP_SETUP;
      S_DIV:   cmd.op = OP_DIV;
      S_ALPHA: cmd.op = OP_ALPHA;
      S_MUL:   cmd.op = OP_MUL;
      S_BLEND: cmd.op = OP_BLEND;
      S_RRD:   cmd.op = OP_RRD;
      S_RWR:   cmd.op = OP_RWR;
      S_ORD:   cmd.op = OP_ORD;
      S_OUT:   if (!stat.out_busy) cmd.op = OP_OUT;
      S_ERR: begin
        if (!stat.out_busy) begin
          cmd.op        = OP_OUT;
          cmd.short_err = 1'b1;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  // next state and loop counters
  always_comb begin
    state_nxt = state_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    x_nxt     = x_r;
    jj_nxt    = jj_r;
    ii_nxt    = ii_r;
    bit_nxt   = bit_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_func == FUNC_START) begin
          c_nxt = '0;
          k_nxt = '0;
          x_nxt = '0;
          state_nxt = short_kv ? S_ERR : S_CRD;
        end
      end
      S_CRD: state_nxt = S_WRW;
      S_WRW: begin
        if (x_r == deg) begin
          jj_nxt    = j_first;
          ii_nxt    = i_first;
          state_nxt = S_KRD1;
        end else begin
          x_nxt     = 3'(x_r + 3'd1);
          state_nxt = S_CRD;
        end
      end
      S_KRD1: state_nxt = S_KRD2;
      S_KRD2: state_nxt = S_SETUP;
      S_SETUP: begin
        bit_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        bit_nxt = 5'(bit_r + 5'd1);
        if (bit_r == 5'(QBITS - 1)) state_nxt = S_ALPHA;
      end
      S_ALPHA: state_nxt = S_MUL;
      S_MUL:   state_nxt = S_BLEND;
      S_BLEND: begin
        if (ii_r == jj_r) begin
          if (jj_r == j_final) begin
            state_nxt = S_RRD;
          end else begin
            jj_nxt    = 3'(jj_r + 3'd1);
            ii_nxt    = i_first;
            state_nxt = S_KRD1;
          end
        end else begin
          ii_nxt    = 3'(ii_r - 3'd1);
          state_nxt = S_KRD1;
        end
      end
      S_RRD: state_nxt = S_RWR;
      S_RWR: begin
        x_nxt = '0;
        if (k_r != 3'(deg - 3'd1)) begin
          k_nxt     = 3'(k_r + 3'd1);
          state_nxt = S_CRD;
        end else if (c_r != nc_m1) begin
          k_nxt     = '0;
          c_nxt     = 3'(c_r + 3'd1);
          state_nxt = S_CRD;
        end else begin
          k_nxt     = '0;
          c_nxt     = '0;
          state_nxt = S_ORD;
        end
      end
      S_ORD: state_nxt = S_OUT;
      S_OUT: begin
        if (!stat.out_busy) begin
          if (out_last) begin
            state_nxt = S_IDLE;
          end else begin
            if (c_r == nc_m1) begin
              c_nxt = '0;
              k_nxt = 3'(k_r + 3'd1);
            end else begin
              c_nxt = 3'(c_r + 3'd1);
            end
            state_nxt = S_ORD;
          end
        end
      end
      S_ERR: if (!stat.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      c_r     <= '0;
      k_r     <= '0;
      x_r     <= '0;
      jj_r    <= '0;
      ii_r    <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
      x_r     <= x_nxt;
      jj_r    <= jj_nxt;
      ii_r    <= ii_nxt;
      bit_r   <= bit_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/bekc_dp.sv
// bekc_dp: knot, control, work row and result memories, alpha divider,
// blend multiplier and the output register
// depends on bekc_pkg
`default_nettype none

module bekc_dp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bekc_pkg::in_word_t in_word,
  input  wire bekc_pkg::geom_t  geom,
  input  wire bekc_pkg::cmd_t   cmd,
  output bekc_pkg::stat_t       stat,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output bekc_pkg::out_word_t   out_word
);
  import bekc_pkg::*;

  // memories
  logic signed [31:0] knot_mem [32];
  logic signed [31:0] ctrl_mem [64];
  logic signed [31:0] wr_mem   [8];
  logic signed [31:0] res_mem  [64];

  logic signed [31:0] kd0_r, kd1_r, cd_r, wd0_r, wd1_r, rd_r;
  logic signed [32:0] num_r, diff_r;
  logic [32:0]        ad_r;
  logic               neg_r, dzero_r, ovf_r, zero_r;
  logic [34:0]        rem_r;
  logic [QBITS-1:0]   nlow_r, q_r;
  logic signed [17:0] alpha_r;
  logic signed [31:0] p_r;
  logic signed [50:0] prod_r;
  logic               out_valid_r;
  out_word_t          out_r;

  logic [3:0]  tx, oidx;
  logic [4:0]  taddr;
  logic [2:0]  dest, pidx, deg;
  logic [5:0]  rc_addr;
  logic signed [32:0] den, diffc;
  logic [32:0] an, ad;
  logic [49:0] nfull;
  logic [33:0] dv;
  logic [34:0] trial;
  logic [QBITS-1:0] qsat;
  logic signed [51:0] bsum;
  logic signed [35:0] bsh;
  logic signed [31:0] bres;

  assign deg  = geom.deg;
  assign tx   = 4'(cmd.k) + 4'(cmd.jj);
  assign dest = 3'(cmd.ii + 3'(geom.side));
  assign pidx = 3'(dest - 3'd1);
  assign oidx = geom.side ? 4'(4'(deg) + 4'(cmd.ii) - 4'(cmd.jj))
                          : 4'(4'(cmd.ii) + 4'(deg) + 4'd1 - 4'(cmd.jj));
  assign rc_addr = {cmd.k, cmd.c};

  // merged knot sequence t: old window at 0..14, new knots at 16..23
  always_comb begin
    if (!geom.side) begin
      taddr = (tx <= 4'(deg)) ? {1'b1, tx} : {1'b0, tx};
    end else if (tx < 4'(deg - 3'd1)) begin
      taddr = {1'b0, 4'(tx + 4'd1)};
    end else begin
      taddr = {1'b1, 4'(tx - 4'(deg - 3'd1))};
    end
  end

  // host loads
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      unique case (in_word.func)
        FUNC_OLD_KNOT: if (in_word.slot != 4'd15) knot_mem[{1'b0, in_word.slot}] <= in_word.value;
        FUNC_NEW_KNOT: if (!in_word.slot[3]) knot_mem[{2'b10, in_word.slot[2:0]}] <= in_word.value;
        FUNC_CTRL:     if (!in_word.slot[3])
                         ctrl_mem[{in_word.coord_sel, in_word.slot[2:0]}] <= in_word.value;
        default: ;
      endcase
    end
  end

  // knot reads, two ports
  always_ff @(posedge clk) begin
    if (cmd.op == OP_KRD1) begin
      kd0_r <= knot_mem[taddr];
      kd1_r <= knot_mem[{1'b0, cmd.ii, 1'b0} >> 1];
    end else if (cmd.op == OP_KRD2) begin
      kd0_r <= knot_mem[{1'b0, oidx}];
      kd1_r <= knot_mem[{2'b00, cmd.ii}];
    end
  end

  // control store read
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CRD) cd_r <= ctrl_mem[{cmd.c, cmd.x}];
  end

  // work row: one write, two registered reads
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRW) wr_mem[cmd.x] <= cd_r;
    else if (cmd.op == OP_BLEND) wr_mem[dest] <= bres;
    if (cmd.op == OP_KRD2) begin
      wd0_r <= wr_mem[pidx];
      wd1_r <= wr_mem[dest];
    end else if (cmd.op == OP_RRD) begin
      wd0_r <= wr_mem[deg];
    end
  end

  // result store
  always_ff @(posedge clk) begin
    if (cmd.op == OP_RWR) res_mem[rc_addr] <= wd0_r;
    if (cmd.op == OP_ORD) rd_r <= res_mem[rc_addr];
  end

  // divider setup values
  assign den   = 33'(kd0_r) - 33'(kd1_r);
  assign an    = num_r[32] ? 33'(-num_r) : 33'(num_r);
  assign ad    = den[32] ? 33'(-den) : 33'(den);
  assign nfull = {an, 17'd0} + 50'(ad);
  assign dv    = {ad_r, 1'b0};
  assign trial = {rem_r[33:0], nlow_r[QBITS-1]};
  assign qsat  = ovf_r ? '1 : q_r;
  assign diffc = 33'(wd1_r) - 33'(p_r);

  // blend sum, round half up then floor shift
  assign bsum = 52'($signed({p_r, 16'd0})) + 52'(prod_r) + 52'sd32768;
  assign bsh  = 36'(bsum >>> 16);
  always_comb begin
    if (bsh > 36'sd2147483647)       bres = 32'sh7fffffff;
    else if (bsh < -36'sd2147483648) bres = 32'sh80000000;
    else                             bres = 32'(bsh);
  end

  // alpha: restoring division one quotient bit a cycle, then multiply
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_KRD2: num_r <= 33'(kd0_r) - 33'(kd1_r);
      OP_SETUP: begin
        ad_r    <= ad;
        neg_r   <= num_r[32] ^ den[32];
        dzero_r <= (den == '0);
        ovf_r   <= (35'(nfull[49:QBITS]) >= 35'({ad, 1'b0}));
        rem_r   <= 35'(nfull[49:QBITS]);
        nlow_r  <= nfull[QBITS-1:0];
        q_r     <= '0;
        p_r     <= wd0_r;
      end
      OP_DIV: begin
        if (trial >= 35'(dv)) begin
          rem_r <= trial - 35'(dv);
          q_r   <= {q_r[QBITS-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[QBITS-2:0], 1'b0};
        end
        nlow_r <= {nlow_r[QBITS-2:0], 1'b0};
      end
      OP_ALPHA: begin
        if (dzero_r) begin
          alpha_r <= '0;
        end else if (neg_r) begin
          alpha_r <= (qsat > 19'd131072) ? -18'sd131072 : 18'(-$signed({1'b0, qsat}));
        end else begin
          alpha_r <= (qsat > 19'd131071) ? 18'sd131071 : 18'(qsat);
        end
        diff_r <= diffc;
      end
      OP_MUL: prod_r <= 51'(alpha_r) * 51'(diff_r);
      default: ;
    endcase
  end

  // sticky zero span flag for the run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r <= 1'b0;
    end else if (cmd.op == OP_CLRZ) begin
      zero_r <= 1'b0;
    end else if (cmd.op == OP_ALPHA && dzero_r) begin
      zero_r <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      if (cmd.short_err) begin
        out_r <= '{point_index: '0, coord_id: '0, coordinate: '0,
                   error: ERR_SHORT, last: 1'b1};
      end else begin
        out_r.point_index <= geom.side ?
          12'(geom.last_knot - 12'({deg, 1'b0}) + 12'(cmd.k)) : 12'(cmd.k);
        out_r.coord_id    <= cmd.c;
        out_r.coordinate  <= rd_r;
        out_r.error       <= zero_r ? ERR_ZERO : ERR_OK;
        out_r.last        <= cmd.last;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_word      = out_r;
  assign stat.out_busy = out_valid_r;

endmodule

`default_nettype wire

// File: design/bspline_end_knot_change.sv
// bspline_end_knot_change: B-spline end knot change with end control point update
// loads are taken while idle; a start works each result point and coordinate through
// the blending triangle using the bit-serial alpha divider; results leave one word
// at a time, each after the prior is taken; one item is worked at a time
// synchronous active-low reset: degree 3, side 0, coord_count 1, last_knot 0
// depends on bekc_pkg, bekc_ctrl, bekc_dp
`default_nettype none

module bspline_end_knot_change (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire bekc_pkg::in_word_t   in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output bekc_pkg::out_word_t       out_word,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [11:0]          cfg_wdata
);
  import bekc_pkg::*;

  logic [2:0]  degree_r;
  logic        side_r;
  logic [3:0]  coord_cnt_r;
  logic [11:0] last_knot_r;
  geom_t       geom;
  logic [3:0]  nc;
  cmd_t        cmd;
  stat_t       stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r    <= 3'd3;
      side_r      <= 1'b0;
      coord_cnt_r <= 4'd1;
      last_knot_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEGREE:    degree_r    <= cfg_wdata[2:0];
        REG_SIDE:      side_r      <= cfg_wdata[0];
        REG_COORD_CNT: coord_cnt_r <= cfg_wdata[3:0];
        REG_LAST_KNOT: last_knot_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp degree and count
  assign geom.deg       = (degree_r == 3'd0) ? 3'd1 : degree_r;
  assign geom.side      = side_r;
  assign geom.last_knot = last_knot_r;
  assign nc = (coord_cnt_r == 4'd0) ? 4'd1 :
              (coord_cnt_r > 4'(MAX_COORDS)) ? 4'(MAX_COORDS) : coord_cnt_r;

  bekc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_word.func),
    .geom     (geom),
    .nc       (nc),
    .stat     (stat),
    .cmd      (cmd)
  );

  bekc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .geom      (geom),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire
